FILE: hdl/ibc_pkg.sv
// ----------------------------------------------------------------------------
// ibc_pkg
// shared types and constants for the imu bias calibration block
// ----------------------------------------------------------------------------
package ibc_pkg;

    localparam int OUTPUT_FRAC_BITS = 16;
    localparam int OFFSET_FRAC_BITS = 8;
    localparam int COUNT_WIDTH      = 16;
    localparam int AXES             = 6;
    localparam int RAW_W            = 16;
    localparam int SUM_W            = 32;
    localparam int OFS_W            = RAW_W + OFFSET_FRAC_BITS;
    localparam int CORR_W           = OFS_W + 1;
    localparam int GAIN_W           = 30;
    localparam int PROD_W           = CORR_W + GAIN_W + 1;
    localparam int GAIN_SHIFT       = 40;
    localparam int RND_SHIFT        = GAIN_SHIFT + OFFSET_FRAC_BITS - OUTPUT_FRAC_BITS;
    localparam int DIVD_W           = SUM_W + OFFSET_FRAC_BITS;
    localparam int DSTEP_W          = $clog2(DIVD_W);
    localparam int OUT_W            = 32;

    localparam logic [GAIN_W-1:0] ACCEL_GAIN = 30'd658337956;
    localparam logic [GAIN_W-1:0] GYRO_GAIN  = 30'd146489298;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_NOTREADY = 2'd1;
    localparam logic [1:0] ST_TAKEN    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    localparam logic REG_DEVICE_READY  = 1'b0;
    localparam logic REG_CALIB_SAMPLES = 1'b1;

    typedef struct packed {
        logic acc;
        logic mul;
        logic div_load;
        logic div_step;
        logic div_finish;
    } ibc_lane_cmd_t;

endpackage

FILE: hdl/ibc_if.sv
// ----------------------------------------------------------------------------
// ibc_in_if / ibc_out_if
// valid/ready channels for raw samples and converted results
// ----------------------------------------------------------------------------
interface ibc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic signed [15:0] raw_accel_x;
    logic signed [15:0] raw_accel_y;
    logic signed [15:0] raw_accel_z;
    logic signed [15:0] raw_gyro_x;
    logic signed [15:0] raw_gyro_y;
    logic signed [15:0] raw_gyro_z;

    modport source (output valid, func, raw_accel_x, raw_accel_y, raw_accel_z,
                    raw_gyro_x, raw_gyro_y, raw_gyro_z, input ready);
    modport sink   (input valid, func, raw_accel_x, raw_accel_y, raw_accel_z,
                    raw_gyro_x, raw_gyro_y, raw_gyro_z, output ready);
endinterface

interface ibc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] accel_x_ms2;
    logic signed [31:0] accel_y_ms2;
    logic signed [31:0] accel_z_ms2;
    logic signed [31:0] rate_x_rads;
    logic signed [31:0] rate_y_rads;
    logic signed [31:0] rate_z_rads;

    modport source (output valid, status, accel_x_ms2, accel_y_ms2, accel_z_ms2,
                    rate_x_rads, rate_y_rads, rate_z_rads, input ready);
    modport sink   (input valid, status, accel_x_ms2, accel_y_ms2, accel_z_ms2,
                    rate_x_rads, rate_y_rads, rate_z_rads, output ready);
endinterface

FILE: hdl/ibc_lane.sv
// ----------------------------------------------------------------------------
// ibc_lane
// one axis: bias sum, serial offset divider, correction and unit scaling
// ----------------------------------------------------------------------------
module ibc_lane #(
    parameter bit IS_GYRO = 1'b0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ibc_pkg::ibc_lane_cmd_t                 cmd,
    input  logic signed [ibc_pkg::RAW_W-1:0]       raw,
    input  logic                                   calibrated,
    input  logic [ibc_pkg::COUNT_WIDTH-1:0]        den,
    output logic signed [ibc_pkg::OUT_W-1:0]       data
);

    localparam logic [ibc_pkg::GAIN_W-1:0] GAIN =
        IS_GYRO ? ibc_pkg::GYRO_GAIN : ibc_pkg::ACCEL_GAIN;
    localparam int REM_W = ibc_pkg::COUNT_WIDTH + 1;
    localparam int CORR_W = ibc_pkg::CORR_W;

    logic signed [ibc_pkg::SUM_W-1:0]  sum_reg;
    logic signed [ibc_pkg::OFS_W-1:0]  offset_reg;
    logic signed [ibc_pkg::PROD_W-1:0] prod_reg;
    logic [ibc_pkg::DIVD_W-1:0]        quo_reg;
    logic [REM_W-1:0]                  rem_reg;
    logic                              neg_reg;

    logic [ibc_pkg::DIVD_W-1:0]        sum_mag;
    logic [REM_W-1:0]                  rem_sh;
    logic                              q_bit;
    logic [REM_W-1:0]                  rem_next;
    logic [ibc_pkg::OFS_W:0]           q_rnd;
    logic signed [ibc_pkg::CORR_W-1:0] corr;
    logic [ibc_pkg::PROD_W-1:0]        p_mag;
    logic [ibc_pkg::PROD_W-1:0]        p_rnd;
    logic signed [ibc_pkg::OUT_W:0]    res;

    always_comb
    begin
        // magnitude of sum scaled to offset fraction bits
        sum_mag = sum_reg[ibc_pkg::SUM_W-1]
            ? {(ibc_pkg::DIVD_W - ibc_pkg::SUM_W)'(0), -sum_reg} << ibc_pkg::OFFSET_FRAC_BITS
            : {(ibc_pkg::DIVD_W - ibc_pkg::SUM_W)'(0), sum_reg} << ibc_pkg::OFFSET_FRAC_BITS;
        rem_sh   = {rem_reg[REM_W-2:0], quo_reg[ibc_pkg::DIVD_W-1]};
        q_bit    = rem_sh >= {1'b0, den};
        rem_next = q_bit ? rem_sh - {1'b0, den} : rem_sh;
        // half away from zero: bump when twice the remainder reaches the divisor
        q_rnd = {1'b0, quo_reg[ibc_pkg::OFS_W-1:0]}
              + (ibc_pkg::OFS_W + 1)'({rem_reg, 1'b0} >= {2'b00, den});
        corr = ($signed({raw, ibc_pkg::OFFSET_FRAC_BITS'(0)}))
             - (calibrated ? CORR_W'(offset_reg) : CORR_W'(0));
        p_mag = prod_reg[ibc_pkg::PROD_W-1] ? -prod_reg : prod_reg;
        p_rnd = (p_mag + (ibc_pkg::PROD_W'(1) << (ibc_pkg::RND_SHIFT - 1)))
                >> ibc_pkg::RND_SHIFT;
        res = prod_reg[ibc_pkg::PROD_W-1] ? -$signed(p_rnd[ibc_pkg::OUT_W:0])
                                         : $signed(p_rnd[ibc_pkg::OUT_W:0]);
        if (res > $signed({2'b00, {(ibc_pkg::OUT_W-1){1'b1}}}))
            data = {1'b0, {(ibc_pkg::OUT_W-1){1'b1}}};
        else if (res < $signed({2'b11, {(ibc_pkg::OUT_W-1){1'b0}}}))
            data = {1'b1, {(ibc_pkg::OUT_W-1){1'b0}}};
        else
            data = res[ibc_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            if (cmd.acc)
                sum_reg <= sum_reg + ibc_pkg::SUM_W'(raw);
            else if (cmd.div_load)
                sum_reg <= '0;
            if (cmd.div_finish)
                offset_reg <= neg_reg ? -q_rnd[ibc_pkg::OFS_W-1:0] : q_rnd[ibc_pkg::OFS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= corr * $signed({1'b0, GAIN});
        if (cmd.div_load)
        begin
            quo_reg <= sum_mag;
            rem_reg <= '0;
            neg_reg <= sum_reg[ibc_pkg::SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[ibc_pkg::DIVD_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

endmodule

FILE: hdl/ibc_merge.sv
// ----------------------------------------------------------------------------
// ibc_merge
// gathers lane results and status into the output register
// ----------------------------------------------------------------------------
module ibc_merge (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic [1:0]                             status_in,
    input  logic signed [ibc_pkg::OUT_W-1:0]       lane_data [ibc_pkg::AXES],
    output logic [1:0]                             status,
    output logic signed [ibc_pkg::OUT_W-1:0]       data [ibc_pkg::AXES]
);

    logic [1:0]                       status_reg;
    logic signed [ibc_pkg::OUT_W-1:0] data_reg [ibc_pkg::AXES];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_in;
            for (int i = 0; i < ibc_pkg::AXES; i++)
                data_reg[i] <= (status_in == ibc_pkg::ST_VALID) ? lane_data[i] : '0;
        end
    end

    assign status = status_reg;
    assign data   = data_reg;

endmodule

FILE: hdl/imu_six_axis_bias_calibration_top.sv
// ----------------------------------------------------------------------------
// imu_six_axis_bias_calibration_top
// six-axis mean bias calibration and unit conversion, one lane per axis
// ----------------------------------------------------------------------------
//  channel  dir  content
//  in_ch    in   func + six raw axes (signed 16 bit)
//  out_ch   out  status + three accel (m/s^2) + three rates (rad/s), Q15.16
//  cfg      in   we / index / data: device_ready, calib_samples
//
//  not-ready and calibration-taken items go straight to S_OUT, a measure
//  passes S_MEAS, a completing calibration item passes S_LOAD, S_DIV
//  (40-step restoring divider per lane) and S_FIN; each result waits in S_OUT
//  one item in flight; in_ch.ready is low until out_ch result is taken
//  reset clears sums, offsets, counter and calibrated flag, and returns the
//  config registers to their defaults
module imu_six_axis_bias_calibration_top (
    input  logic         clk,
    input  logic         rst_n,
    ibc_in_if.sink       in_ch,
    ibc_out_if.source    out_ch,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAS,
        S_LOAD,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t                            state_reg;
    logic                              device_ready_reg;
    logic [ibc_pkg::COUNT_WIDTH-1:0]   calib_samples_reg;
    logic [ibc_pkg::COUNT_WIDTH-1:0]   counter_reg;
    logic [ibc_pkg::COUNT_WIDTH-1:0]   den_reg;
    logic                              calibrated_reg;
    logic [ibc_pkg::DSTEP_W-1:0]       step_reg;

    logic                              accept;
    logic [ibc_pkg::COUNT_WIDTH:0]     count_next;
    logic [ibc_pkg::COUNT_WIDTH-1:0]   target;
    ibc_pkg::ibc_lane_cmd_t            cmd;
    logic                              merge_load;
    logic [1:0]                        merge_status;
    logic signed [ibc_pkg::RAW_W-1:0]  raw [ibc_pkg::AXES];
    logic signed [ibc_pkg::OUT_W-1:0]  lane_data [ibc_pkg::AXES];
    logic signed [ibc_pkg::OUT_W-1:0]  out_data [ibc_pkg::AXES];

    assign accept     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);

    // a zero sample count behaves as one
    assign target     = (calib_samples_reg == '0) ? ibc_pkg::COUNT_WIDTH'(1) : calib_samples_reg;
    assign count_next = {1'b0, counter_reg} + (ibc_pkg::COUNT_WIDTH + 1)'(1);

    assign raw[0] = in_ch.raw_accel_x;
    assign raw[1] = in_ch.raw_accel_y;
    assign raw[2] = in_ch.raw_accel_z;
    assign raw[3] = in_ch.raw_gyro_x;
    assign raw[4] = in_ch.raw_gyro_y;
    assign raw[5] = in_ch.raw_gyro_z;

    // lane commands: accumulate and multiply act on the accepted item directly
    always_comb
    begin
        cmd            = '0;
        cmd.acc        = accept && device_ready_reg && in_ch.func;
        cmd.mul        = accept && device_ready_reg && !in_ch.func;
        cmd.div_load   = (state_reg == S_LOAD);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.div_finish = (state_reg == S_FIN);

        merge_load   = 1'b0;
        merge_status = ibc_pkg::ST_VALID;
        if (accept && !device_ready_reg)
        begin
            merge_load   = 1'b1;
            merge_status = ibc_pkg::ST_NOTREADY;
        end
        else if (accept && in_ch.func && (count_next < {1'b0, target}))
        begin
            merge_load   = 1'b1;
            merge_status = ibc_pkg::ST_TAKEN;
        end
        else if (state_reg == S_MEAS)
        begin
            merge_load   = 1'b1;
            merge_status = ibc_pkg::ST_VALID;
        end
        else if (state_reg == S_FIN)
        begin
            merge_load   = 1'b1;
            merge_status = ibc_pkg::ST_DONE;
        end
    end

    // sequencer and calibration bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            device_ready_reg  <= 1'b0;
            calib_samples_reg <= ibc_pkg::COUNT_WIDTH'(64);
            counter_reg       <= '0;
            den_reg           <= '0;
            calibrated_reg    <= 1'b0;
            step_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ibc_pkg::REG_DEVICE_READY:  device_ready_reg  <= cfg_data[0];
                    ibc_pkg::REG_CALIB_SAMPLES: calib_samples_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!device_ready_reg)
                            state_reg <= S_OUT;
                        else if (in_ch.func)
                        begin
                            if (count_next >= {1'b0, target})
                            begin
                                // run complete: divide by the samples seen
                                den_reg   <= count_next[ibc_pkg::COUNT_WIDTH-1:0];
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                counter_reg <= count_next[ibc_pkg::COUNT_WIDTH-1:0];
                                state_reg   <= S_OUT;
                            end
                        end
                        else
                            state_reg <= S_MEAS;
                    end
                end
                S_MEAS:
                    state_reg <= S_OUT;
                S_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + ibc_pkg::DSTEP_W'(1);
                    if (step_reg == ibc_pkg::DSTEP_W'(ibc_pkg::DIVD_W - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    counter_reg    <= '0;
                    calibrated_reg <= 1'b1;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // three accel lanes then three gyro lanes
    for (genvar g = 0; g < ibc_pkg::AXES; g++)
    begin : g_lane
        ibc_lane #(
            .IS_GYRO (g >= 3)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .raw        (raw[g]),
            .calibrated (calibrated_reg),
            .den        (den_reg),
            .data       (lane_data[g])
        );
    end

    ibc_merge u_merge (
        .clk       (clk),
        .load      (merge_load),
        .status_in (merge_status),
        .lane_data (lane_data),
        .status    (out_ch.status),
        .data      (out_data)
    );

    assign out_ch.accel_x_ms2 = out_data[0];
    assign out_ch.accel_y_ms2 = out_data[1];
    assign out_ch.accel_z_ms2 = out_data[2];
    assign out_ch.rate_x_rads = out_data[3];
    assign out_ch.rate_y_rads = out_data[4];
    assign out_ch.rate_z_rads = out_data[5];

endmodule

FILE: hdl/ibc_checker.sv
// ----------------------------------------------------------------------------
// ibc_checker
// port-level checks for the imu bias calibration block
// ----------------------------------------------------------------------------
module ibc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] accel_x_ms2,
    input logic [31:0] rate_z_rads
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("pending result dropped or changed");

    a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ibc_pkg::ST_VALID |-> accel_x_ms2 == '0 && rate_z_rads == '0)
        else $error("data nonzero on a non-data result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an accepted item");

endmodule

bind imu_six_axis_bias_calibration_top ibc_checker u_ibc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .accel_x_ms2 (out_ch.accel_x_ms2),
    .rate_z_rads (out_ch.rate_z_rads)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the imu bias calibration block: a directed table of samples and
// register writes, then random calibration and measure runs, each result
// compared against a bit-exact software copy of the offset and scaling math
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic               func;
        logic signed [15:0] axis [ibc_pkg::AXES];
    } sample_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value [ibc_pkg::AXES];
    } reading_t;

    // one row of the directed table: a register write or a sample
    typedef struct {
        bit                 is_write;
        logic               reg_index;
        logic [15:0]        reg_data;
        logic               func;
        logic signed [15:0] fill;
        bit                 typed;
        logic [1:0]         typed_status;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    ibc_in_if  in_ch ();
    ibc_out_if out_ch ();

    imu_six_axis_bias_calibration_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the block state and its registers
    longint   bias_sums [ibc_pkg::AXES];
    longint   bias_offsets [ibc_pkg::AXES];
    int       samples_taken;
    bit       bias_valid;
    bit       shadow_ready;
    int       shadow_samples;

    reading_t pending_readings [$];
    int       error_count;
    int       readings_seen;
    bit       no_idle;

    // ------------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // fixed-point helpers, halves rounded away from zero
    // ------------------------------------------------------------------------
    function automatic longint shift_round(longint num, int sh);
        longint unsigned mag;
        longint unsigned r;
        mag = (num < 0) ? -num : num;
        r   = (mag + (64'd1 << (sh - 1))) >> sh;
        return (num < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint div_round(longint num, longint den);
        longint unsigned mag;
        longint unsigned r;
        mag = (num < 0) ? -num : num;
        r   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // expected reading for one accepted sample; advances the shadow state
    function automatic reading_t predict_reading(sample_t s);
        reading_t rd;
        int       target;
        int       next_count;
        longint   corr;
        longint   gain;
        rd.status = ibc_pkg::ST_VALID;
        for (int i = 0; i < ibc_pkg::AXES; i++)
            rd.value[i] = '0;
        if (!shadow_ready)
        begin
            rd.status = ibc_pkg::ST_NOTREADY;
            return rd;
        end
        if (s.func)
        begin
            // a zero count acts as one
            target = (shadow_samples == 0) ? 1 : shadow_samples;
            if (target > (1 << ibc_pkg::COUNT_WIDTH) - 1)
                target = (1 << ibc_pkg::COUNT_WIDTH) - 1;
            for (int i = 0; i < ibc_pkg::AXES; i++)
                bias_sums[i] += longint'(s.axis[i]);
            next_count = samples_taken + 1;
            if (next_count >= target)
            begin
                for (int i = 0; i < ibc_pkg::AXES; i++)
                begin
                    bias_offsets[i] = div_round(bias_sums[i]
                                                * (64'sd1 << ibc_pkg::OFFSET_FRAC_BITS),
                                                longint'(next_count));
                    bias_sums[i] = 0;
                end
                samples_taken = 0;
                bias_valid    = 1'b1;
                rd.status     = ibc_pkg::ST_DONE;
            end
            else
            begin
                samples_taken = next_count & ((1 << ibc_pkg::COUNT_WIDTH) - 1);
                rd.status     = ibc_pkg::ST_TAKEN;
            end
            return rd;
        end
        for (int i = 0; i < ibc_pkg::AXES; i++)
        begin
            corr = longint'(s.axis[i]) * (64'sd1 << ibc_pkg::OFFSET_FRAC_BITS);
            gain = (i < 3) ? longint'(ibc_pkg::ACCEL_GAIN) : longint'(ibc_pkg::GYRO_GAIN);
            if (bias_valid)
                corr -= bias_offsets[i];
            rd.value[i] = clamp32(shift_round(corr * gain, ibc_pkg::RND_SHIFT));
        end
        return rd;
    endfunction

    // mostly short gaps, sometimes none, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // sample driver: offers one item, waits for the handshake, then either
    // keeps valid high for the next item or drops it for a gap
    // ------------------------------------------------------------------------
    task automatic offer_sample(sample_t s, bit typed, logic [1:0] typed_status);
        reading_t rd;
        int       gap;
        in_ch.valid       <= 1'b1;
        in_ch.func        <= s.func;
        in_ch.raw_accel_x <= s.axis[0];
        in_ch.raw_accel_y <= s.axis[1];
        in_ch.raw_accel_z <= s.axis[2];
        in_ch.raw_gyro_x  <= s.axis[3];
        in_ch.raw_gyro_y  <= s.axis[4];
        in_ch.raw_gyro_z  <= s.axis[5];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        rd = predict_reading(s);
        if (typed)
        begin
            // status taken from the directed table; data is zero for non-valid
            rd.status = typed_status;
            for (int i = 0; i < ibc_pkg::AXES; i++)
                rd.value[i] = '0;
        end
        pending_readings.push_back(rd);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let every reading come back and the block settle before a write
    task automatic drain_block();
        @(posedge clk);
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == ibc_pkg::REG_DEVICE_READY)
            shadow_ready = data[0];
        else
            shadow_samples = data;
    endtask

    function automatic logic signed [15:0] random_axis();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // directed table, then random calibration and measure phases
    // ------------------------------------------------------------------------
    row_t    directed [$];
    sample_t smp;

    function automatic row_t reg_row(logic idx, logic [15:0] data);
        row_t r;
        r = '{default: '0};
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    function automatic row_t item_row(logic func, logic signed [15:0] fill,
                                      bit typed, logic [1:0] st);
        row_t r;
        r = '{default: '0};
        r.func         = func;
        r.fill         = fill;
        r.typed        = typed;
        r.typed_status = st;
        return r;
    endfunction

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= ibc_pkg::REG_DEVICE_READY;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= 1'b0;
        in_ch.raw_accel_x <= '0;
        in_ch.raw_accel_y <= '0;
        in_ch.raw_accel_z <= '0;
        in_ch.raw_gyro_x  <= '0;
        in_ch.raw_gyro_y  <= '0;
        in_ch.raw_gyro_z  <= '0;
        error_count    = 0;
        no_idle        = 1'b0;
        shadow_ready   = 1'b0;
        shadow_samples = 64;
        samples_taken  = 0;
        bias_valid     = 1'b0;
        for (int i = 0; i < ibc_pkg::AXES; i++)
        begin
            bias_sums[i]    = 0;
            bias_offsets[i] = 0;
        end

        // device not ready out of reset
        directed.push_back(item_row(1'b0, 16'sh7fff, 1, ibc_pkg::ST_NOTREADY));
        directed.push_back(item_row(1'b1, 16'sh8000, 1, ibc_pkg::ST_NOTREADY));
        // zero count acts as one: every calibration sample completes a run
        directed.push_back(reg_row(ibc_pkg::REG_DEVICE_READY, 16'd1));
        directed.push_back(reg_row(ibc_pkg::REG_CALIB_SAMPLES, 16'd0));
        directed.push_back(item_row(1'b0, 16'sh7fff, 0, ibc_pkg::ST_VALID));
        directed.push_back(item_row(1'b0, 16'sh8000, 0, ibc_pkg::ST_VALID));
        directed.push_back(item_row(1'b0, 16'sh0000, 0, ibc_pkg::ST_VALID));
        directed.push_back(item_row(1'b1, 16'sh8000, 1, ibc_pkg::ST_DONE));
        // offset of full negative scale, then both extremes measured against it without saturating
        directed.push_back(item_row(1'b0, 16'sh7fff, 0, ibc_pkg::ST_VALID));
        directed.push_back(item_row(1'b0, 16'sh8000, 0, ibc_pkg::ST_VALID));
        // three-sample run with a rounded mean
        directed.push_back(reg_row(ibc_pkg::REG_CALIB_SAMPLES, 16'd3));
        directed.push_back(item_row(1'b1, 16'sh7fff, 1, ibc_pkg::ST_TAKEN));
        directed.push_back(item_row(1'b1, 16'sh7fff, 1, ibc_pkg::ST_TAKEN));
        directed.push_back(item_row(1'b1, -16'sd1, 1, ibc_pkg::ST_DONE));
        directed.push_back(item_row(1'b0, 16'sh1234, 0, ibc_pkg::ST_VALID));
        // count lowered mid-run: next sample completes at once
        directed.push_back(reg_row(ibc_pkg::REG_CALIB_SAMPLES, 16'd8));
        for (int k = 0; k < 5; k++)
            directed.push_back(item_row(1'b1, 16'(1000 * k - 2000), 1, ibc_pkg::ST_TAKEN));
        directed.push_back(reg_row(ibc_pkg::REG_CALIB_SAMPLES, 16'd2));
        directed.push_back(item_row(1'b1, 16'sd77, 1, ibc_pkg::ST_DONE));
        // largest count: recalibration run starts, old offsets stay in use
        directed.push_back(reg_row(ibc_pkg::REG_CALIB_SAMPLES, 16'hffff));
        directed.push_back(item_row(1'b1, 16'sh4000, 1, ibc_pkg::ST_TAKEN));
        directed.push_back(item_row(1'b0, 16'sh4000, 0, ibc_pkg::ST_VALID));
        // not ready again leaves state alone
        directed.push_back(reg_row(ibc_pkg::REG_DEVICE_READY, 16'd0));
        directed.push_back(item_row(1'b0, 16'sh0001, 1, ibc_pkg::ST_NOTREADY));
        directed.push_back(item_row(1'b1, 16'sh0001, 1, ibc_pkg::ST_NOTREADY));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            if (directed[n].is_write)
            begin
                drain_block();
                write_register(directed[n].reg_index, directed[n].reg_data);
            end
            else
            begin
                smp.func = directed[n].func;
                for (int i = 0; i < ibc_pkg::AXES; i++)
                    smp.axis[i] = directed[n].fill + 16'(i * 3);
                offer_sample(smp, directed[n].typed, directed[n].typed_status);
            end
        end

        // random phases: mostly complete calibration runs with random content,
        // measures in between, one not-ready phase, one phase with no idling
        for (int ph = 0; ph < 9; ph++)
        begin
            drain_block();
            write_register(ibc_pkg::REG_DEVICE_READY, (ph == 4) ? 16'd0 : 16'd1);
            case (ph)
                0:       write_register(ibc_pkg::REG_CALIB_SAMPLES, 16'd1);
                3:       write_register(ibc_pkg::REG_CALIB_SAMPLES, 16'hffff);
                6:       write_register(ibc_pkg::REG_CALIB_SAMPLES, 16'd0);
                default: write_register(ibc_pkg::REG_CALIB_SAMPLES,
                                        16'($urandom_range(2, 9)));
            endcase
            no_idle = (ph == 7);
            for (int k = 0; k < ((ph == 4) ? 20 : 48); k++)
            begin
                smp.func = ($urandom_range(0, 99) < 55);
                for (int i = 0; i < ibc_pkg::AXES; i++)
                    smp.axis[i] = random_axis();
                offer_sample(smp, 0, ibc_pkg::ST_VALID);
            end
            no_idle = 1'b0;
        end

        drain_block();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random ready, one long hold-off so the input stalls
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && readings_seen >= 120)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare every accepted item with the oldest expected reading
    initial
    begin
        reading_t want;
        logic signed [31:0] got [ibc_pkg::AXES];
        readings_seen = 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                readings_seen++;
                got[0] = out_ch.accel_x_ms2;
                got[1] = out_ch.accel_y_ms2;
                got[2] = out_ch.accel_z_ms2;
                got[3] = out_ch.rate_x_rads;
                got[4] = out_ch.rate_y_rads;
                got[5] = out_ch.rate_z_rads;
                if (pending_readings.size() == 0)
                begin
                    error_count++;
                    $display("%t: unexpected item, status %0d", $realtime, out_ch.status);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        error_count++;
                        $display("%t: status expected %0d got %0d",
                                 $realtime, want.status, out_ch.status);
                    end
                    for (int i = 0; i < ibc_pkg::AXES; i++)
                        if (got[i] !== want.value[i])
                        begin
                            error_count++;
                            $display("%t: axis %0d expected %0d got %0d",
                                     $realtime, i, want.value[i], got[i]);
                        end
                end
            end
        end
    end

endmodule

FILE: imu_six_axis_bias_calibration_top.f
hdl/ibc_pkg.sv
hdl/ibc_if.sv
hdl/ibc_lane.sv
hdl/ibc_merge.sv
hdl/imu_six_axis_bias_calibration_top.sv
hdl/ibc_checker.sv
tb/testbench.sv
